// ===== hw/rtl/paeh_pkg.sv =====
// paeh_pkg: types, constants and helper functions shared by the photon
// angle/energy histogram modules. No dependencies.
`default_nettype none
package paeh_pkg;
	localparam int MAX_ENERGY_BINS   = 64;
	localparam int MAX_POLAR_BINS    = 32;
	localparam int MAX_AZIMUTH_BINS  = 32;
	localparam int LOG_FRACTION_BITS = 10;
	localparam int EW = $clog2(MAX_ENERGY_BINS);
	localparam int PW = $clog2(MAX_POLAR_BINS);
	localparam int AW = $clog2(MAX_AZIMUTH_BINS);
	localparam int ADDR_W = EW + PW + AW;
	localparam int DEPTH  = MAX_ENERGY_BINS * MAX_POLAR_BINS * MAX_AZIMUTH_BINS;
	localparam int LOG_STEPS = 16;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_E_REJ   = 3'd1,
		ST_P_REJ   = 3'd2,
		ST_A_REJ   = 3'd3,
		ST_READ_OK = 3'd4,
		ST_RD_BAD  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CFG_EMIN  = 3'd0,
		CFG_EMAX  = 3'd1,
		CFG_LGMIN = 3'd2,
		CFG_SCALE = 3'd3,
		CFG_EBINS = 3'd4,
		CFG_PBINS = 3'd5,
		CFG_ABINS = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_LOG, S_MUL, S_BIN, S_RD, S_RD2, S_UPD, S_OUT
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // capture input beat
		logic clr_we;    // write zero at clear address
		logic check;     // range checks, log setup
		logic log_step;  // one squaring step
		logic mul;       // energy, angle and weight-count products
		logic bin;       // clamp bins, form address
		logic rd;        // issue memory read
		logic upd;       // saturating add and write back
		logic out_load;  // load output register
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic rejected;
	} sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/photon_angle_energy_histogram_top.sv =====
// photon_angle_energy_histogram_top: log-binned 3D photon histogram.
// Depends on paeh_pkg, paeh_ctrl, paeh_dp.
//
//  channel | signals                                  | beat content
//  s_axis  | tvalid tready tdata[151:0] tuser[0]      | input item
//  m_axis  | tvalid tready tdata[79:0] tuser[2:0]     | result item
//  cfg     | valid ready index data                   | register write
//
// Add: a beat is checked, passes the squaring steps of the log2 unit, then
// products, binning, memory read and write-back; a rejected add goes straight
// to output, a read after its memory read. One item in flight at a time.
// After reset a clearing pass writes zero to all 65536 memory entries, one per
// cycle, before s_axis_tready rises; config writes are accepted throughout.
// The result register holds a finished beat while m_axis stalls; the block
// then waits in its output step before loading the next result.
`default_nettype none
module photon_angle_energy_histogram_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// photon_energy, polar_angle, azimuth_angle, particle_weight, photon_count,
	// read_energy_index, read_polar_index, read_azimuth_index, pad
	input  wire logic [151:0] s_axis_tdata,
	// mode
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// bin_value, energy_bin, polar_bin, azimuth_bin
	output logic [79:0]       m_axis_tdata,
	// status
	output logic [2:0]        m_axis_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import paeh_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_fire;
	logic out_valid_q;
	logic [2:0]  o_status;
	logic [63:0] o_value;
	logic [5:0]  o_ebin;
	logic [4:0]  o_pbin, o_abin;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	paeh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_valid_q && !m_axis_tready), .sts(sts),
		.cmd(cmd), .in_ready(s_axis_tready)
	);

	paeh_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_mode(s_axis_tuser), .in_data(s_axis_tdata[147:0]),
		.o_status(o_status), .o_value(o_value),
		.o_ebin(o_ebin), .o_pbin(o_pbin), .o_abin(o_abin)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {o_abin, o_pbin, o_ebin, o_value};
	assign m_axis_tuser = o_status;
endmodule
`default_nettype wire

// ===== hw/rtl/paeh_ctrl.sv =====
// paeh_ctrl: sequencer for clear pass, add and read items.
// Depends on paeh_pkg.
`default_nettype none
module paeh_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic            out_busy,
	input  wire paeh_pkg::sts_t  sts,
	output paeh_pkg::cmd_t       cmd,
	output logic                 in_ready
);
	import paeh_pkg::*;
	state_t state_q, state_d;
	logic [4:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK) step_q <= '0;
			else if (state_q == S_LOG) step_q <= step_q + 5'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.is_read) state_d = S_RD;
				else if (sts.rejected) state_d = S_OUT;
				else state_d = S_LOG;
			end
			S_LOG: begin
				cmd.log_step = 1'b1;
				if (step_q == 5'(LOG_STEPS - 1)) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_BIN;
			end
			S_BIN: begin
				cmd.bin = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_RD2;
			end
			S_RD2: state_d = sts.is_read ? S_OUT : S_UPD;
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/paeh_dp.sv =====
// paeh_dp: datapath with config registers, log2 unit, bin arithmetic and
// histogram memory. Depends on paeh_pkg.
`default_nettype none
module paeh_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  paeh_pkg::cmd_t              cmd,
	output paeh_pkg::sts_t              sts,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [31:0]            cfg_data,
	input  wire logic                   in_mode,
	input  wire logic [147:0]           in_data,
	output logic [2:0]                  o_status,
	output logic [63:0]                 o_value,
	output logic [5:0]                  o_ebin,
	output logic [4:0]                  o_pbin,
	output logic [4:0]                  o_abin
);
	import paeh_pkg::*;

	logic [31:0] emin_q, emax_q, scale_q;
	logic [20:0] lgmin_q;
	logic [6:0]  ebins_q;
	logic [5:0]  pbins_q, abins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emin_q <= 32'd25600; emax_q <= 32'd256000000; lgmin_q <= 21'd959700;
			scale_q <= 32'd315660; ebins_q <= 7'd64; pbins_q <= 6'd32; abins_q <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EMIN:  emin_q <= cfg_data;
				CFG_EMAX:  emax_q <= cfg_data;
				CFG_LGMIN: lgmin_q <= cfg_data[20:0];
				CFG_SCALE: scale_q <= cfg_data;
				CFG_EBINS: ebins_q <= cfg_data[6:0];
				CFG_PBINS: pbins_q <= cfg_data[5:0];
				CFG_ABINS: abins_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// bins in use
	logic [6:0] ne;
	logic [5:0] np, na;
	always_comb begin
		ne = (ebins_q == 7'd0) ? 7'd1 : (ebins_q > 7'(MAX_ENERGY_BINS)) ?
			7'(MAX_ENERGY_BINS) : ebins_q;
		np = (pbins_q == 6'd0) ? 6'd1 : (pbins_q > 6'(MAX_POLAR_BINS)) ?
			6'(MAX_POLAR_BINS) : pbins_q;
		na = (abins_q == 6'd0) ? 6'd1 : (abins_q > 6'(MAX_AZIMUTH_BINS)) ?
			6'(MAX_AZIMUTH_BINS) : abins_q;
	end

	// captured item
	logic        mode_q;
	logic [31:0] en_q, wt_q, cnt_q;
	logic signed [17:0] th_q, ph_q;
	logic [5:0]  rie_q;
	logic [4:0]  rip_q, ria_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			en_q <= in_data[31:0];
			th_q <= in_data[49:32];
			ph_q <= in_data[67:50];
			wt_q <= in_data[99:68];
			cnt_q <= in_data[131:100];
			rie_q <= in_data[137:132];
			rip_q <= in_data[142:138];
			ria_q <= in_data[147:143];
		end
	end

	// checks
	status_t st_c, st_q;
	always_comb begin
		if (mode_q) begin
			if ({1'b0, rie_q} >= ne || {1'b0, rip_q} >= np || {1'b0, ria_q} >= na)
				st_c = ST_RD_BAD;
			else st_c = ST_READ_OK;
		end else if (en_q < emin_q || en_q > emax_q) st_c = ST_E_REJ;
		else if (th_q < 18'sd0 || th_q > 18'sd65536) st_c = ST_P_REJ;
		else if (ph_q < -18'sd32768 || ph_q > 18'sd32768) st_c = ST_A_REJ;
		else st_c = ST_ADDED;
	end
	assign sts.is_read = mode_q;
	assign sts.rejected = (st_c != ST_ADDED);

	// log2 setup: leading one and fraction
	logic [4:0] k_c;
	logic [LOG_FRACTION_BITS-1:0] frac_c;
	logic [62:0] sh_c;
	always_comb begin
		k_c = '0;
		for (int i = 0; i < 32; i++) if (en_q[i]) k_c = 5'(i);
		sh_c = {31'd0, en_q} << (6'd31 - {1'b0, k_c});
		frac_c = sh_c[30 -: LOG_FRACTION_BITS];
	end

	logic [4:0]  k_q;
	logic [31:0] m_q;
	logic [15:0] res_q;
	logic        ezero_q;
	logic [63:0] sq;
	assign sq = {32'd0, m_q} * {32'd0, m_q};
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			st_q <= st_c;
			k_q <= k_c;
			ezero_q <= (en_q == 32'd0);
			m_q <= {2'b01, frac_c, (30 - LOG_FRACTION_BITS)'(0)};
			res_q <= '0;
		end else if (cmd.log_step) begin
			if (sq[61]) begin
				m_q <= sq[61:30] >> 1;
				res_q <= {res_q[14:0], 1'b1};
			end else begin
				m_q <= sq[61:30];
				res_q <= {res_q[14:0], 1'b0};
			end
		end
	end

	// products
	logic [20:0] lg;
	logic [20:0] d;
	assign lg = ezero_q ? 21'd0 : {k_q, res_q};
	assign d  = (lg > lgmin_q) ? lg - lgmin_q : 21'd0;
	logic [52:0] eprod_s1;
	logic [23:0] pprod_s1, aprod_s1;
	logic [63:0] add_s1;
	logic [17:0] phs;
	assign phs = ph_q + 18'sd32768;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			eprod_s1 <= {32'd0, d} * {21'd0, scale_q};
			pprod_s1 <= th_q[17:0] * {12'd0, np};
			aprod_s1 <= phs * {12'd0, na};
			add_s1 <= {32'd0, wt_q} * {32'd0, cnt_q};
		end
	end

	// bins
	logic [5:0] ie_q;
	logic [4:0] ip_q, ia_q;
	logic [20:0] et;
	logic [7:0]  pt, at;
	assign et = eprod_s1[52:32];
	assign pt = pprod_s1[23:16];
	assign at = aprod_s1[23:16];
	always_ff @(posedge clk) begin
		if (cmd.check && mode_q) begin
			ie_q <= rie_q; ip_q <= rip_q; ia_q <= ria_q;
		end else if (cmd.bin) begin
			ie_q <= (et >= {14'd0, ne}) ? 6'(ne - 7'd1) : et[5:0];
			ip_q <= (pt >= {2'd0, np}) ? 5'(np - 6'd1) : pt[4:0];
			ia_q <= (at >= {2'd0, na}) ? 5'(na - 6'd1) : at[4:0];
		end
	end

	// memory and clear pass
	logic [63:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic [63:0] rdata_q;
	logic [ADDR_W-1:0] addr;
	logic [64:0] sum;
	logic [63:0] nv;
	assign addr = {ia_q, ip_q, ie_q};
	assign sts.clr_done = (clr_q == ADDR_W'(DEPTH - 1));
	assign sum = {1'b0, rdata_q} + {1'b0, add_s1};
	assign nv = sum[64] ? '1 : sum[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_we && !sts.clr_done) clr_q <= clr_q + ADDR_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) mem[clr_q] <= '0;
		else if (cmd.upd) mem[addr] <= nv;
		if (cmd.rd) rdata_q <= mem[addr];
	end

	logic [63:0] val_q;
	always_ff @(posedge clk) begin
		if (cmd.upd) val_q <= nv;
		else if (cmd.rd) val_q <= '0;
		else if (cmd.check) val_q <= '0;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_status <= st_q;
			unique case (st_q)
				ST_READ_OK: o_value <= rdata_q;
				ST_ADDED:   o_value <= val_q;
				default:    o_value <= '0;
			endcase
			if (st_q == ST_E_REJ || st_q == ST_P_REJ || st_q == ST_A_REJ) begin
				o_ebin <= '0; o_pbin <= '0; o_abin <= '0;
			end else begin
				o_ebin <= ie_q; o_pbin <= ip_q; o_abin <= ia_q;
			end
		end
	end
endmodule
`default_nettype wire
